// File: rtl/afsc_pkg.sv
// Shared constants, codes and helper functions of the adaptive fuzzy sliding-mode controller.
// Used by the channel interfaces and by the top level; depends on nothing.
package afsc_pkg;

  localparam int FUZZY_SETS = 5;
  localparam int RULE_COUNT = 25;
  localparam int ROM_LEN    = 64;
  localparam int MU_W       = 17;

  localparam logic [MU_W-1:0]  MU_FLOOR    = 17'd7;
  localparam logic signed [15:0] KICK_TORQUE = 16'sd4352;
  localparam logic [17:0]      TS_Q24      = 18'd167772;
  localparam logic signed [27:0] FIRST_RATE = 28'sd66;
  localparam logic signed [31:0] W_RESET   = 32'sd6554;
  localparam logic [11:0]      IDX_MAX     = 12'd4095;

  localparam logic [2:0] REG_SLOPE  = 3'd0;
  localparam logic [2:0] REG_SWITCH = 3'd1;
  localparam logic [2:0] REG_LINEAR = 3'd2;
  localparam logic [2:0] REG_GAMMA1 = 3'd3;
  localparam logic [2:0] REG_GAMMA2 = 3'd4;

  typedef logic signed [15:0] sample_t;
  typedef logic [MU_W-1:0] mu_rom_t [0:ROM_LEN-1];

  function automatic mu_rom_t build_mu_rom();
    longint unsigned one;
    longint unsigned q;
    longint unsigned q2;
    longint unsigned g;
    longint unsigned r;
    longint unsigned e;
    mu_rom_t rom;
    one = 64'd1 << 30;
    q   = 64'd1069555701;
    q2  = (q * q + (one >> 1)) >> 30;
    g   = one;
    r   = q;
    for (int k = 0; k < ROM_LEN; k++) begin
      e = (g + 64'd8192) >> 14;
      rom[k] = (e < 64'd7) ? MU_FLOOR : e[MU_W-1:0];
      g = (g * r + (one >> 1)) >> 30;
      r = (r * q2 + (one >> 1)) >> 30;
    end
    return rom;
  endfunction

  localparam mu_rom_t MU_ROM = build_mu_rom();

  function automatic logic signed [67:0] rnd(input logic signed [67:0] v, input int unsigned n);
    return (v + (68'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > 68'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -68'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

// File: rtl/afsc_if.sv
// Valid/ready channel interfaces for tilt samples and torque results.
// Depends on afsc_pkg for the payload types.
interface afsc_in_if;
  logic              valid;
  logic              ready;
  afsc_pkg::sample_t tilt_sample;
  modport source (output valid, output tilt_sample, input ready);
  modport sink (input valid, input tilt_sample, output ready);
endinterface

interface afsc_out_if;
  logic              valid;
  logic              ready;
  afsc_pkg::sample_t wheel_torque;
  logic              kick_applied;
  logic              saturated;
  modport source (output valid, output wheel_torque, output kick_applied, output saturated,
                  input ready);
  modport sink (input valid, input wheel_torque, input kick_applied, input saturated,
                output ready);
endinterface

// File: rtl/adaptive_fuzzy_sliding_controller.sv
// Top level of the adaptive fuzzy sliding-mode tilt controller: sequencer, shared
// multiplier, shared restoring divider and the rule memories. Depends on afsc_pkg, afsc_if.
//
//   port     dir  beat contents
//   in_ch    in   tilt_sample (Q2.14)
//   out_ch   out  wheel_torque (Q8.8), kick_applied, saturated
//   cfg_*    in   cfg_we, cfg_idx, cfg_data (one register per write)
//
// Each sample is worked through in sequence on the single multiplier and the
// one-bit-per-cycle divider.
// Reset is synchronous; the f and g tables read as 0.1 until rewritten.
// in_ch is ready only while no sample is in work; a finished result waits in the
// output register, and a new sample may be taken meanwhile.
module adaptive_fuzzy_sliding_controller #(
  parameter int FUZZY_SETS = afsc_pkg::FUZZY_SETS,
  parameter int RULE_COUNT = afsc_pkg::RULE_COUNT
) (
  input  logic        clk,
  input  logic        rst_n,
  afsc_in_if.sink     in_ch,
  afsc_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [15:0] cfg_data
);

  localparam int MU_AW   = $clog2(FUZZY_SETS);
  localparam int RULE_AW = $clog2(RULE_COUNT);
  localparam logic signed [17:0] CEN0 = 18'(-(FUZZY_SETS - 1) * 429);

  localparam logic [5:0] S_IDLE = 6'd0,  S_SCALE = 6'd1,  S_SURF = 6'd2,  S_MEMB = 6'd3;
  localparam logic [5:0] S_MEMW = 6'd4,  S_NUMA = 6'd5,   S_NUMB = 6'd6,  S_NUMC = 6'd7;
  localparam logic [5:0] S_NUMD = 6'd8,  S_XIA = 6'd9,    S_XIB = 6'd10,  S_DIV = 6'd11;
  localparam logic [5:0] S_XIC = 6'd12,  S_XID = 6'd13,   S_XIE = 6'd14,  S_NA = 6'd15;
  localparam logic [5:0] S_NB = 6'd16,   S_NC = 6'd17,    S_UQ = 6'd18,   S_GA = 6'd19;
  localparam logic [5:0] S_GB = 6'd20,   S_GC = 6'd21,    S_UW = 6'd22,   S_UA = 6'd23;
  localparam logic [5:0] S_UB = 6'd24,   S_UC = 6'd25,    S_UD = 6'd26,   S_UE = 6'd27;
  localparam logic [5:0] S_UF = 6'd28,   S_UG = 6'd29,    S_UH = 6'd30,   S_UI = 6'd31;
  localparam logic [5:0] S_UJ = 6'd32,   S_OUT = 6'd33;

  logic [5:0] state_r, state_nxt, ret_r, ret_nxt;
  logic [15:0] slope_r, switch_r, linear_r, gamma1_r, gamma2_r;
  logic signed [15:0] a_r, a_nxt, prev_r, prev_nxt;
  logic [11:0] idx_r, idx_nxt;
  logic signed [27:0] rate_r, rate_nxt, s_r, s_nxt;
  logic [MU_AW-1:0] j_r, j_nxt, q_r, q_nxt;
  logic [RULE_AW-1:0] p_r, p_nxt, r_r, r_nxt;
  logic [39:0] den_r, den_nxt;
  logic [16:0] mua_r, mua_nxt, xi_r, xi_nxt;
  logic signed [55:0] fx_r, fx_nxt, gx_r, gx_nxt;
  logic signed [41:0] t1_r, t1_nxt;
  logic neg_r, neg_nxt, sat_r, sat_nxt;
  logic signed [31:0] u_r, u_nxt, pf_r, pf_nxt, pg_r, pg_nxt;
  logic signed [49:0] tmp_r, tmp_nxt;
  logic signed [47:0] acc_r, acc_nxt;
  logic [39:0] div_rem_r, div_rem_nxt, div_d_r, div_d_nxt;
  logic [57:0] div_n_r, div_n_nxt, div_q_r, div_q_nxt;
  logic [5:0] div_cnt_r, div_cnt_nxt;
  logic signed [65:0] prod_r;
  logic signed [32:0] mul_a, mul_b;
  logic [RULE_COUNT-1:0] vld_r, vld_nxt;
  logic out_valid_r, out_valid_nxt, out_kick_r, out_kick_nxt, out_sat_r, out_sat_nxt;
  logic signed [15:0] out_torque_r, out_torque_nxt;

  logic [16:0] mu_mem [0:FUZZY_SETS-1];
  logic [33:0] num_mem [0:RULE_COUNT-1];
  logic [16:0] xi_mem [0:RULE_COUNT-1];
  logic signed [31:0] f_mem [0:RULE_COUNT-1];
  logic signed [31:0] g_mem [0:RULE_COUNT-1];
  logic [16:0] mu_rd_r, mu_wdata, xi_rd_r;
  logic [33:0] num_rd_r;
  logic signed [31:0] f_rd_r, g_rd_r, f_val, g_val, f_wdata, g_wdata;
  logic [MU_AW-1:0] mu_addr;
  logic mu_we, num_we, xi_we, f_we, g_we;

  logic signed [17:0] cen, dif;
  logic [16:0] dabs;
  logic [13:0] kfull;
  logic [5:0] kidx;
  logic signed [16:0] tdiff;
  logic signed [55:0] ndiv;
  logic [40:0] trial;
  logic signed [39:0] fxr, gxr;
  logic signed [41:0] nsum, nabs, swt;
  logic [39:0] gabs;
  logic signed [23:0] trq;
  logic kick;

  assign f_val = vld_r[r_r] ? f_rd_r : afsc_pkg::W_RESET;
  assign g_val = vld_r[r_r] ? g_rd_r : afsc_pkg::W_RESET;

  assign cen   = CEN0 + $signed(18'(j_r) * 18'd858);
  assign dif   = 18'(a_r) - cen;
  assign dabs  = dif[17] ? 17'(-dif) : dif[16:0];
  assign kfull = 14'((prod_r[29:0] + 30'd32768) >> 16);
  assign kidx  = (kfull > 14'd63) ? 6'd63 : kfull[5:0];
  assign tdiff = 17'(a_r) - 17'(prev_r);
  assign ndiv  = (56'(num_rd_r) <<< 16) + 56'(den_r >> 1);
  assign trial = {div_rem_r, div_n_r[div_cnt_r]};
  assign fxr   = 40'(afsc_pkg::rnd(68'(fx_r), 16));
  assign gxr   = 40'(afsc_pkg::rnd(68'(gx_r), 16));
  assign swt   = (s_r > 0) ? 42'($signed({22'b0, switch_r, 4'b0})) :
                 (s_r < 0) ? -42'($signed({22'b0, switch_r, 4'b0})) : 42'sd0;
  assign nsum  = 42'(-fxr) + t1_r - swt - 42'(afsc_pkg::rnd(68'(prod_r), 12));
  assign nabs  = nsum[41] ? -nsum : nsum;
  assign gabs  = gxr[39] ? 40'(-gxr) : 40'(gxr);
  assign trq   = 24'(afsc_pkg::rnd(68'(u_r), 9));
  assign kick  = (idx_r >= 12'd201 && idx_r <= 12'd225) || (idx_r >= 12'd401 && idx_r <= 12'd425)
              || (idx_r >= 12'd601 && idx_r <= 12'd625) || (idx_r >= 12'd801 && idx_r <= 12'd825);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SCALE: begin
        mul_a = 33'({1'b0, slope_r});
        mul_b = 33'(a_r) <<< 2;
      end
      S_MEMB: begin
        mul_a = 33'(dabs);
        mul_b = 33'sd2445;
      end
      S_NUMC: begin
        mul_a = 33'(mua_r);
        mul_b = (32'(p_r) < 32'(FUZZY_SETS)) ? 33'(mu_rd_r) : 33'sd0;
      end
      S_XIC: begin
        mul_a = 33'(f_val);
        mul_b = 33'(div_q_r[16:0]);
      end
      S_XID: begin
        mul_a = 33'(g_val);
        mul_b = 33'(xi_r) + 33'(afsc_pkg::MU_FLOOR);
      end
      S_NA: begin
        mul_a = 33'({1'b0, slope_r});
        mul_b = 33'(rate_r);
      end
      S_NB: begin
        mul_a = 33'({1'b0, linear_r});
        mul_b = 33'(s_r);
      end
      S_GA: begin
        mul_a = 33'({1'b0, gamma1_r});
        mul_b = 33'(s_r);
      end
      S_GB: begin
        mul_a = 33'({1'b0, gamma2_r});
        mul_b = 33'(s_r);
      end
      S_UA: begin
        mul_a = 33'(pf_r);
        mul_b = 33'(xi_rd_r);
      end
      S_UC: begin
        mul_a = tmp_r[32:0];
        mul_b = 33'(afsc_pkg::TS_Q24);
      end
      S_UD: begin
        mul_a = 33'(pg_r);
        mul_b = 33'(xi_rd_r) + 33'(afsc_pkg::MU_FLOOR);
      end
      S_UF: begin
        mul_a = tmp_r[32:0];
        mul_b = 33'(u_r);
      end
      S_UH: begin
        mul_a = 33'($signed(tmp_r[49:24]));
        mul_b = 33'(afsc_pkg::TS_Q24);
      end
      S_UI: begin
        mul_a = 33'(tmp_r[23:0]);
        mul_b = 33'(afsc_pkg::TS_Q24);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;  ret_nxt = ret_r;  a_nxt = a_r;  prev_nxt = prev_r;
    idx_nxt = idx_r;  rate_nxt = rate_r;  s_nxt = s_r;  j_nxt = j_r;  q_nxt = q_r;
    p_nxt = p_r;  r_nxt = r_r;  den_nxt = den_r;  mua_nxt = mua_r;  xi_nxt = xi_r;
    fx_nxt = fx_r;  gx_nxt = gx_r;  t1_nxt = t1_r;  neg_nxt = neg_r;  sat_nxt = sat_r;
    u_nxt = u_r;  pf_nxt = pf_r;  pg_nxt = pg_r;  tmp_nxt = tmp_r;  acc_nxt = acc_r;
    div_rem_nxt = div_rem_r;  div_d_nxt = div_d_r;  div_n_nxt = div_n_r;
    div_q_nxt = div_q_r;  div_cnt_nxt = div_cnt_r;  vld_nxt = vld_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    out_kick_nxt = out_kick_r;  out_sat_nxt = out_sat_r;  out_torque_nxt = out_torque_r;
    mu_addr = '0;  mu_we = 1'b0;  mu_wdata = afsc_pkg::MU_ROM[kidx];
    num_we = 1'b0;  xi_we = 1'b0;  f_we = 1'b0;  g_we = 1'b0;
    f_wdata = afsc_pkg::sat32(68'(f_val) + afsc_pkg::rnd(68'(prod_r), 24));
    g_wdata = afsc_pkg::sat32(68'(g_val) + 68'(acc_r) + afsc_pkg::rnd(68'(prod_r), 24));
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          a_nxt = in_ch.tilt_sample;
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        rate_nxt = (idx_r == 12'd0) ? afsc_pkg::FIRST_RATE : 28'(tdiff) * 28'sd400;
        state_nxt = S_SURF;
      end
      S_SURF: begin
        s_nxt = rate_r + 28'(afsc_pkg::rnd(68'(prod_r), 12));
        j_nxt = '0;
        state_nxt = S_MEMB;
      end
      S_MEMB: begin
        state_nxt = S_MEMW;
      end
      S_MEMW: begin
        mu_we = 1'b1;
        if (32'(j_r) == FUZZY_SETS - 1) begin
          r_nxt = '0;  p_nxt = '0;  q_nxt = '0;  den_nxt = '0;
          state_nxt = S_NUMA;
        end else begin
          j_nxt = j_r + 1'b1;
          state_nxt = S_MEMB;
        end
      end
      S_NUMA: begin
        mu_addr = (32'(p_r) < 32'(FUZZY_SETS)) ? p_r[MU_AW-1:0] : '0;
        state_nxt = S_NUMB;
      end
      S_NUMB: begin
        mua_nxt = mu_rd_r;
        mu_addr = q_r;
        state_nxt = S_NUMC;
      end
      S_NUMC: begin
        state_nxt = S_NUMD;
      end
      S_NUMD: begin
        num_we = 1'b1;
        den_nxt = den_r + 40'(prod_r[33:0]);
        if (32'(q_r) == FUZZY_SETS - 1) begin
          q_nxt = '0;
          p_nxt = p_r + 1'b1;
        end else begin
          q_nxt = q_r + 1'b1;
        end
        if (32'(r_r) == RULE_COUNT - 1) begin
          r_nxt = '0;  fx_nxt = '0;  gx_nxt = '0;
          state_nxt = S_XIA;
        end else begin
          r_nxt = r_r + 1'b1;
          state_nxt = S_NUMA;
        end
      end
      S_XIA: begin
        state_nxt = S_XIB;
      end
      S_XIB: begin
        div_q_nxt = '0;
        div_d_nxt = den_r;
        div_n_nxt = 58'(ndiv);
        div_rem_nxt = 40'(ndiv[55:17]);
        div_cnt_nxt = 6'd16;
        ret_nxt = S_XIC;
        state_nxt = (den_r == 40'd0) ? S_XIC : S_DIV;
      end
      S_DIV: begin
        if (trial >= {1'b0, div_d_r}) begin
          div_rem_nxt = 40'(trial - {1'b0, div_d_r});
          div_q_nxt[div_cnt_r] = 1'b1;
        end else begin
          div_rem_nxt = trial[39:0];
        end
        div_cnt_nxt = div_cnt_r - 1'b1;
        if (div_cnt_r == 6'd0) begin
          state_nxt = ret_r;
        end
      end
      S_XIC: begin
        xi_nxt = div_q_r[16:0];
        xi_we = 1'b1;
        state_nxt = S_XID;
      end
      S_XID: begin
        fx_nxt = fx_r + 56'(prod_r);
        state_nxt = S_XIE;
      end
      S_XIE: begin
        gx_nxt = gx_r + 56'(prod_r);
        if (32'(r_r) == RULE_COUNT - 1) begin
          state_nxt = S_NA;
        end else begin
          r_nxt = r_r + 1'b1;
          state_nxt = S_XIA;
        end
      end
      S_NA: begin
        state_nxt = S_NB;
      end
      S_NB: begin
        t1_nxt = 42'(afsc_pkg::rnd(68'(prod_r), 12));
        state_nxt = S_NC;
      end
      S_NC: begin
        neg_nxt = nsum[41] ^ gxr[39];
        if (gxr == 40'sd0) begin
          sat_nxt = (nsum != 42'sd0);
          u_nxt = (nsum > 0) ? 32'sh7fffffff : (nsum < 0) ? 32'sh80000000 : 32'sd0;
          state_nxt = S_GA;
        end else begin
          div_q_nxt = '0;
          div_d_nxt = gabs;
          div_n_nxt = {nabs[41:0], 16'b0};
          div_rem_nxt = '0;
          div_cnt_nxt = 6'd57;
          ret_nxt = S_UQ;
          state_nxt = S_DIV;
        end
      end
      S_UQ: begin
        if (neg_r) begin
          sat_nxt = (div_q_r > 58'd2147483648);
          u_nxt = sat_nxt ? 32'sh80000000 : 32'(-$signed(div_q_r));
        end else begin
          sat_nxt = (div_q_r > 58'd2147483647);
          u_nxt = sat_nxt ? 32'sh7fffffff : 32'(div_q_r);
        end
        state_nxt = S_GA;
      end
      S_GA: begin
        state_nxt = S_GB;
      end
      S_GB: begin
        pf_nxt = 32'(afsc_pkg::rnd(68'(prod_r), 12));
        state_nxt = S_GC;
      end
      S_GC: begin
        pg_nxt = 32'(afsc_pkg::rnd(68'(prod_r), 12));
        r_nxt = '0;
        state_nxt = S_UW;
      end
      S_UW: begin
        state_nxt = S_UA;
      end
      S_UA: begin
        state_nxt = S_UB;
      end
      S_UB: begin
        tmp_nxt = 50'(afsc_pkg::rnd(68'(prod_r), 16));
        state_nxt = S_UC;
      end
      S_UC: begin
        state_nxt = S_UD;
      end
      S_UD: begin
        f_we = 1'b1;
        state_nxt = S_UE;
      end
      S_UE: begin
        tmp_nxt = 50'(afsc_pkg::rnd(68'(prod_r), 16));
        state_nxt = S_UF;
      end
      S_UF: begin
        state_nxt = S_UG;
      end
      S_UG: begin
        tmp_nxt = 50'(afsc_pkg::rnd(68'(prod_r), 16));
        state_nxt = S_UH;
      end
      S_UH: begin
        state_nxt = S_UI;
      end
      S_UI: begin
        acc_nxt = 48'(prod_r);
        state_nxt = S_UJ;
      end
      S_UJ: begin
        g_we = 1'b1;
        vld_nxt[r_r] = 1'b1;
        if (32'(r_r) == RULE_COUNT - 1) begin
          state_nxt = S_OUT;
        end else begin
          r_nxt = r_r + 1'b1;
          state_nxt = S_UW;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_kick_nxt = kick;
          if (kick) begin
            out_torque_nxt = afsc_pkg::KICK_TORQUE;
            out_sat_nxt = 1'b0;
          end else if (trq > 24'sd32767) begin
            out_torque_nxt = 16'sh7fff;
            out_sat_nxt = 1'b1;
          end else if (trq < -24'sd32768) begin
            out_torque_nxt = 16'sh8000;
            out_sat_nxt = 1'b1;
          end else begin
            out_torque_nxt = trq[15:0];
            out_sat_nxt = sat_r;
          end
          prev_nxt = a_r;
          idx_nxt = (idx_r == afsc_pkg::IDX_MAX) ? idx_r : idx_r + 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mu_rd_r  <= mu_mem[mu_addr];
    num_rd_r <= num_mem[r_r];
    xi_rd_r  <= xi_mem[r_r];
    f_rd_r   <= f_mem[r_r];
    g_rd_r   <= g_mem[r_r];
    if (mu_we) begin
      mu_mem[j_r] <= mu_wdata;
    end
    if (num_we) begin
      num_mem[r_r] <= prod_r[33:0];
    end
    if (xi_we) begin
      xi_mem[r_r] <= div_q_r[16:0];
    end
    if (f_we) begin
      f_mem[r_r] <= f_wdata;
    end
    if (g_we) begin
      g_mem[r_r] <= g_wdata;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    ret_r <= ret_nxt;  a_r <= a_nxt;  rate_r <= rate_nxt;  s_r <= s_nxt;
    j_r <= j_nxt;  q_r <= q_nxt;  p_r <= p_nxt;  r_r <= r_nxt;  den_r <= den_nxt;
    mua_r <= mua_nxt;  xi_r <= xi_nxt;  fx_r <= fx_nxt;  gx_r <= gx_nxt;  t1_r <= t1_nxt;
    neg_r <= neg_nxt;  sat_r <= sat_nxt;  u_r <= u_nxt;  pf_r <= pf_nxt;  pg_r <= pg_nxt;
    tmp_r <= tmp_nxt;  acc_r <= acc_nxt;  div_rem_r <= div_rem_nxt;  div_d_r <= div_d_nxt;
    div_n_r <= div_n_nxt;  div_q_r <= div_q_nxt;  div_cnt_r <= div_cnt_nxt;
    out_kick_r <= out_kick_nxt;  out_sat_r <= out_sat_nxt;  out_torque_r <= out_torque_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      prev_r <= '0;
      idx_r <= '0;
      vld_r <= '0;
      out_valid_r <= 1'b0;
      slope_r <= 16'd8765;
      switch_r <= 16'd9953;
      linear_r <= 16'd12861;
      gamma1_r <= 16'd0;
      gamma2_r <= 16'd0;
    end else begin
      state_r <= state_nxt;
      prev_r <= prev_nxt;
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          afsc_pkg::REG_SLOPE:  slope_r <= cfg_data;
          afsc_pkg::REG_SWITCH: switch_r <= cfg_data;
          afsc_pkg::REG_LINEAR: linear_r <= cfg_data;
          afsc_pkg::REG_GAMMA1: gamma1_r <= cfg_data;
          afsc_pkg::REG_GAMMA2: gamma2_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.wheel_torque = out_torque_r;
  assign out_ch.kick_applied = out_kick_r;
  assign out_ch.saturated    = out_sat_r;

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_rem_r < div_d_r))
    else $error("divider remainder not below divisor");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("result raised outside the output step");

  a_kick_nosat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_kick_r && out_sat_r))
    else $error("kick result flagged as saturated");

  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == S_SCALE))
    else $error("accepted sample did not start the sequence");

endmodule
